### rtl/core/source_text_tokenizer_defines.svh
// Assertion macros for the source text tokenizer.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define STT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define STT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define STT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define STT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/stt_pkg.sv
// Shared constants and character classes for the source text tokenizer.
// No dependencies; used by every module of the block.
package stt_pkg;

   localparam int POS_BITS_DEFAULT = 16;
   localparam int KIND_W           = 3;
   localparam int GROUP_MAX        = 3;  // most records one byte can cause
   localparam int CNT_W            = 2;
   localparam int RESULT_DEPTH     = 8;

   localparam logic [KIND_W-1:0] KIND_EOF     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_KEYWORD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FRAC    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STRING  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNDEF   = 3'd6;

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_VTAB      = 8'h0B;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_PLUS      = 8'h2B;
   localparam logic [7:0] CH_COMMA     = 8'h2C;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_LESS      = 8'h3C;
   localparam logic [7:0] CH_EQUAL     = 8'h3D;
   localparam logic [7:0] CH_GREATER   = 8'h3E;
   localparam logic [7:0] CH_UPPER_E   = 8'h45;
   localparam logic [7:0] CH_LBRACKET  = 8'h5B;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACKET  = 8'h5D;
   localparam logic [7:0] CH_LOWER_E   = 8'h65;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
             c == CH_FORMFEED || c == CH_RETURN;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      case (c)
         CH_PLUS, CH_MINUS, CH_EQUAL, CH_LESS, CH_GREATER, CH_LBRACE, CH_RBRACE,
         CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN, CH_DOT, CH_COLON,
         CH_APOS, CH_COMMA: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

### rtl/core/source_text_tokenizer.sv
// Top level of the source text tokenizer: stream ports, flow control.
// Depends on stt_pkg, stt_lexer, stt_result_fifo and the defines header.
//
// Streaming lexer. Each req transfer carries one source byte (req_tlast marks
// the last byte of the text). The block tracks byte index, row and column,
// skips whitespace and line/block comments, and sends one rsp transfer per
// token: keyword, int, frac, string, symbol or undefined, followed by an EOF
// record when a NUL byte or the last byte arrives; after that the position
// restarts at index 0, row 1, column 1. rsp_tuser carries the token kind,
// rsp_tdata the positions, and rsp_tlast marks the last record caused by a
// given byte. A byte is registered on entry, classified in the following
// cycle, and its records (at most three) are written to an eight-entry
// result queue, whose head drives rsp. Bytes are taken at one per cycle as
// long as the queue holds at most two records while a byte is in
// classification, or at most five when none is; so the sustained rate is
// one byte per cycle while bytes yield at most one record each and rsp is
// ready, and the rsp side, at one record per cycle, sets the rate when
// they yield more. Positions saturate at 2^POS_BITS-1.
`include "source_text_tokenizer_defines.svh"
module source_text_tokenizer #(
   parameter int POS_BITS  = stt_pkg::POS_BITS_DEFAULT,
   localparam int REC_W    = stt_pkg::KIND_W + 4 * POS_BITS,
   localparam int ENT_W    = REC_W + 1,
   localparam int DATA_W   = ((4 * POS_BITS + 7) / 8) * 8,
   localparam int LEVEL_W  = $clog2(stt_pkg::RESULT_DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] text_byte
   input  logic                        req_tlast,   // final_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [DATA_W-1:0]           rsp_tdata,   // start_pos, end_pos, line_number,
                                                    // column_number, zero fill
   output logic [stt_pkg::KIND_W-1:0]  rsp_tuser,   // token_kind
   output logic                        rsp_tlast    // run_end
);

   logic                                      load;
   logic                                      busy;
   logic [stt_pkg::CNT_W-1:0]                 push_count;
   logic [stt_pkg::GROUP_MAX-1:0][ENT_W-1:0]  push_data;
   logic [ENT_W-1:0]                          head_data;
   logic [LEVEL_W-1:0]                        level;

   // Reserve room for a full group from the byte in classification and
   // another from the byte about to enter.
   assign req_tready = level <= (busy
                          ? LEVEL_W'(stt_pkg::RESULT_DEPTH - 2 * stt_pkg::GROUP_MAX)
                          : LEVEL_W'(stt_pkg::RESULT_DEPTH - stt_pkg::GROUP_MAX));
   assign load       = req_tvalid && req_tready;

   stt_lexer #(.POS_BITS(POS_BITS)) u_lexer (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_byte  (req_tdata),
      .load_final (req_tlast),
      .busy       (busy),
      .push_count (push_count),
      .push_data  (push_data)
   );

   stt_result_fifo #(.ENT_W(ENT_W)) u_results (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data  (push_data),
      .pop        (rsp_tready),
      .not_empty  (rsp_tvalid),
      .head_data  (head_data),
      .level      (level)
   );

   // Split the record: kind to tuser, positions padded to whole bytes in tdata;
   // the top entry bit is the run end flag.
   assign rsp_tuser = head_data[stt_pkg::KIND_W-1:0];
   assign rsp_tdata = DATA_W'(head_data[REC_W-1:stt_pkg::KIND_W]);
   assign rsp_tlast = head_data[ENT_W-1];

   `STT_ASSERT_IMP(a_ready_leaves_room, clock, reset, load && busy, level <= LEVEL_W'(stt_pkg::RESULT_DEPTH - 2 * stt_pkg::GROUP_MAX), "byte taken without queue room")

endmodule

### rtl/core/stt_lexer.sv
// Input register, scanner state and per-byte record generation.
// Depends on stt_pkg and source_text_tokenizer_defines.svh.
`include "source_text_tokenizer_defines.svh"
module stt_lexer #(
   parameter int POS_BITS = stt_pkg::POS_BITS_DEFAULT,
   localparam int REC_W   = stt_pkg::KIND_W + 4 * POS_BITS,
   localparam int ENT_W   = REC_W + 1
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load,
   input  logic [7:0]                                    load_byte,
   input  logic                                          load_final,
   output logic                                          busy,
   output logic [stt_pkg::CNT_W-1:0]                     push_count,
   output logic [stt_pkg::GROUP_MAX-1:0][ENT_W-1:0]      push_data
);

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR,
      MODE_STRING, MODE_ESCAPE, MODE_NUMBER, MODE_KEYWORD
   } mode_type;

   typedef logic [POS_BITS-1:0] pos_type;

   logic     valid_ff;
   logic     final_ff;
   logic [7:0] byte_ff;
   mode_type mode_ff, mode_in;
   pos_type  idx_ff, idx_in, row_ff, row_in, col_ff, col_in;
   pos_type  ts_ff, ts_in, tr_ff, tr_in, tc_ff, tc_in;
   logic     frac_ff, frac_in;

   logic                        text_end;
   logic [stt_pkg::CNT_W-1:0]   n_rec;
   logic [3:0]                  cand_v;
   logic [3:0][REC_W-1:0]       cand_rec;
   logic [stt_pkg::GROUP_MAX-1:0][ENT_W-1:0] slot;

   function automatic pos_type sat_inc(input pos_type v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic [REC_W-1:0] pack_rec(input logic [stt_pkg::KIND_W-1:0] k,
                                                 input pos_type s, input pos_type e,
                                                 input pos_type r, input pos_type c);
      return {c, r, e, s, k};
   endfunction

   always_comb begin
      logic [7:0] c;
      logic       term;
      logic       disp;
      logic       a_v, b_v, f_v;
      logic [stt_pkg::KIND_W-1:0] a_kind, f_kind;
      c       = byte_ff;
      term    = stt_pkg::is_space(c) || stt_pkg::is_symbol(c) || c == stt_pkg::CH_QUOTE;
      disp    = 1'b0;
      a_v     = 1'b0;
      b_v     = 1'b0;
      f_v     = 1'b0;
      a_kind  = stt_pkg::KIND_KEYWORD;
      f_kind  = stt_pkg::KIND_KEYWORD;
      mode_in = mode_ff;
      idx_in  = idx_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      ts_in   = ts_ff;
      tr_in   = tr_ff;
      tc_in   = tc_ff;
      frac_in = frac_ff;

      // close the pending token, if this byte ends it
      if (c != stt_pkg::CH_NUL) begin
         case (mode_ff)
            MODE_SLASH: begin
               if (c == stt_pkg::CH_SLASH) mode_in = MODE_LINE;
               else if (c == stt_pkg::CH_STAR) mode_in = MODE_BLOCK;
               else if (term) begin
                  a_v  = 1'b1;
                  disp = 1'b1;
               end else mode_in = MODE_KEYWORD;
            end
            MODE_LINE: if (c == stt_pkg::CH_NEWLINE) mode_in = MODE_IDLE;
            MODE_BLOCK: if (c == stt_pkg::CH_STAR) mode_in = MODE_BLOCK_STAR;
            MODE_BLOCK_STAR: begin
               if (c == stt_pkg::CH_SLASH) mode_in = MODE_IDLE;
               else if (c != stt_pkg::CH_STAR) mode_in = MODE_BLOCK;
            end
            MODE_STRING: begin
               if (c == stt_pkg::CH_BACKSLASH) mode_in = MODE_ESCAPE;
               else if (c == stt_pkg::CH_QUOTE) begin
                  a_v     = 1'b1;
                  a_kind  = stt_pkg::KIND_STRING;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_ESCAPE: mode_in = MODE_STRING;
            MODE_NUMBER: begin
               if (stt_pkg::is_digit(c)) begin
                  mode_in = MODE_NUMBER;
               end else if (c == stt_pkg::CH_DOT || c == stt_pkg::CH_LOWER_E ||
                            c == stt_pkg::CH_UPPER_E) begin
                  if (frac_ff) begin
                     a_v    = 1'b1;
                     a_kind = stt_pkg::KIND_UNDEF;
                     disp   = 1'b1;
                  end else frac_in = 1'b1;
               end else begin
                  a_v    = 1'b1;
                  a_kind = frac_ff ? stt_pkg::KIND_FRAC : stt_pkg::KIND_INT;
                  disp   = 1'b1;
               end
            end
            MODE_KEYWORD: begin
               if (term) begin
                  a_v  = 1'b1;
                  disp = 1'b1;
               end
            end
            default: disp = 1'b1;
         endcase
      end

      // start whatever this byte opens
      if (disp) begin
         mode_in = MODE_IDLE;
         if (stt_pkg::is_space(c)) begin
            mode_in = MODE_IDLE;
         end else if (c == stt_pkg::CH_SLASH) begin
            {ts_in, tr_in, tc_in} = {idx_ff, row_ff, col_ff};
            mode_in = MODE_SLASH;
         end else if (c == stt_pkg::CH_QUOTE) begin
            ts_in   = sat_inc(idx_ff);
            tr_in   = row_ff;
            tc_in   = sat_inc(col_ff);
            mode_in = MODE_STRING;
         end else if (stt_pkg::is_digit(c)) begin
            {ts_in, tr_in, tc_in} = {idx_ff, row_ff, col_ff};
            frac_in = 1'b0;
            mode_in = MODE_NUMBER;
         end else if (stt_pkg::is_symbol(c)) begin
            b_v = 1'b1;
         end else begin
            {ts_in, tr_in, tc_in} = {idx_ff, row_ff, col_ff};
            mode_in = MODE_KEYWORD;
         end
      end

      // advance the position, NUL excepted
      if (c != stt_pkg::CH_NUL) begin
         if (c == stt_pkg::CH_NEWLINE) begin
            row_in = sat_inc(row_ff);
            col_in = POS_BITS'(1);
         end else col_in = sat_inc(col_ff);
         idx_in = sat_inc(idx_ff);
      end

      // end of text: flush what is pending, then EOF
      text_end = (c == stt_pkg::CH_NUL) || final_ff;
      case (mode_in)
         MODE_SLASH, MODE_KEYWORD: f_v = text_end;
         MODE_NUMBER: begin
            f_v    = text_end;
            f_kind = frac_in ? stt_pkg::KIND_FRAC : stt_pkg::KIND_INT;
         end
         MODE_STRING, MODE_ESCAPE: begin
            f_v    = text_end;
            f_kind = stt_pkg::KIND_STRING;
         end
         default: f_v = 1'b0;
      endcase

      cand_v      = {text_end, f_v, b_v, a_v};
      cand_rec[0] = pack_rec(a_kind, ts_ff, idx_ff, tr_ff, tc_ff);
      cand_rec[1] = pack_rec(stt_pkg::KIND_SYMBOL, idx_ff, sat_inc(idx_ff), row_ff, col_ff);
      cand_rec[2] = pack_rec(f_kind, ts_in, idx_in, tr_in, tc_in);
      cand_rec[3] = pack_rec(stt_pkg::KIND_EOF, idx_in, idx_in, row_in, col_in);
   end

   // pack the candidates in order into the output slots
   always_comb begin
      logic [stt_pkg::CNT_W-1:0] n;
      n    = '0;
      slot = '0;
      for (int k = 0; k < 4; k++) begin
         if (cand_v[k] && n < stt_pkg::CNT_W'(stt_pkg::GROUP_MAX)) begin
            slot[n] = {1'b0, cand_rec[k]};
            n       = n + 1'b1;
         end
      end
      if (n != '0) slot[n - 1'b1][ENT_W-1] = 1'b1;
      n_rec = n;
   end

   assign busy       = valid_ff;
   assign push_count = valid_ff ? n_rec : '0;
   assign push_data  = slot;

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= load_byte;
         final_ff <= load_final;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         mode_ff  <= MODE_IDLE;
         idx_ff   <= '0;
         row_ff   <= POS_BITS'(1);
         col_ff   <= POS_BITS'(1);
         ts_ff    <= '0;
         tr_ff    <= '0;
         tc_ff    <= '0;
         frac_ff  <= 1'b0;
      end else begin
         valid_ff <= load;
         if (valid_ff) begin
            if (text_end) begin
               mode_ff <= MODE_IDLE;
               idx_ff  <= '0;
               row_ff  <= POS_BITS'(1);
               col_ff  <= POS_BITS'(1);
               ts_ff   <= '0;
               tr_ff   <= '0;
               tc_ff   <= '0;
               frac_ff <= 1'b0;
            end else begin
               mode_ff <= mode_in;
               idx_ff  <= idx_in;
               row_ff  <= row_in;
               col_ff  <= col_in;
               ts_ff   <= ts_in;
               tr_ff   <= tr_in;
               tc_ff   <= tc_in;
               frac_ff <= frac_in;
            end
         end
      end
   end

   `STT_ASSERT_NXT(a_end_restarts, clock, reset, valid_ff && text_end, idx_ff == '0 && mode_ff == MODE_IDLE && row_ff == POS_BITS'(1), "scanner not back at start after end of text")
   `STT_ASSERT_IMP(a_end_gives_eof, clock, reset, valid_ff && text_end, push_count != '0, "end of text produced no record")

endmodule

### rtl/core/stt_result_fifo.sv
// Result queue: takes a group of up to three records per cycle, hands out one.
// Depends on stt_pkg and source_text_tokenizer_defines.svh.
`include "source_text_tokenizer_defines.svh"
module stt_result_fifo #(
   parameter int ENT_W    = stt_pkg::KIND_W + 4 * stt_pkg::POS_BITS_DEFAULT + 1,
   localparam int DEPTH   = stt_pkg::RESULT_DEPTH,
   localparam int PTR_W   = $clog2(DEPTH),
   localparam int LEVEL_W = $clog2(DEPTH + 1)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic [stt_pkg::CNT_W-1:0]                  push_count,
   input  logic [stt_pkg::GROUP_MAX-1:0][ENT_W-1:0]   push_data,
   input  logic                                       pop,
   output logic                                       not_empty,
   output logic [ENT_W-1:0]                           head_data,
   output logic [LEVEL_W-1:0]                         level
);

   logic [ENT_W-1:0]   entry_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, tail_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               do_pop;

   assign not_empty = level_ff != '0;
   assign head_data = entry_ff[head_ff];
   assign level     = level_ff;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      for (int k = 0; k < stt_pkg::GROUP_MAX; k++) begin
         if (stt_pkg::CNT_W'(k) < push_count) entry_ff[tail_ff + PTR_W'(k)] <= push_data[k];
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         tail_ff  <= tail_ff + PTR_W'(push_count);
         head_ff  <= head_ff + PTR_W'(do_pop);
         level_ff <= level_ff + LEVEL_W'(push_count) - LEVEL_W'(do_pop);
      end
   end

   `STT_ASSERT_IMP(a_level_bound, clock, reset, 1'b1, level_ff <= LEVEL_W'(DEPTH), "result queue level beyond depth")
   `STT_ASSERT_IMP(a_no_overflow, clock, reset, push_count != '0, (LEVEL_W + 1)'(level_ff) + (LEVEL_W + 1)'(push_count) <= (LEVEL_W + 1)'(DEPTH), "result queue overflow")

endmodule

### tb/sv/tb_source_text_tokenizer.sv
// Self-checking testbench for source_text_tokenizer: byte stream in, token records out.
// Depends on stt_pkg and the source_text_tokenizer RTL; a scoreboard class inside
// predicts every record and plain tasks drive the stream ports.
module tb_source_text_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import stt_pkg::*;

   localparam int POS_W         = POS_BITS_DEFAULT;
   localparam int DATA_W        = ((4 * POS_W + 7) / 8) * 8;
   localparam int RANDOM_ITEMS  = 360;
   localparam int HOLD_AFTER    = 60;    // records seen before the long receiver hold-off
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 16;    // drain margin after the last expected record; allow plenty

   localparam string SYMBOL_CHARS = "+-=<>{}[]().:',";

   typedef logic [POS_W-1:0] pos_t;
   localparam pos_t POS_TOP = '1;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_SLASH, SCAN_LINE, SCAN_BLOCK, SCAN_BLOCK_STAR,
      SCAN_STRING, SCAN_ESCAPE, SCAN_NUMBER, SCAN_WORD
   } scan_mode_e;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      pos_t              start_pos;
      pos_t              end_pos;
      pos_t              line_no;
      pos_t              col_no;
      logic              run_end;
   } token_rec_t;

   // Scoreboard: lexes each accepted byte on its own copy of the scanner state and
   // queues the records it should cause; each record off the rsp side is checked
   // against the oldest one waiting.
   class token_ledger;
      token_rec_t expected_tokens[$];
      token_rec_t byte_tokens[$];
      scan_mode_e mode;
      pos_t       next_index, next_row, next_col;
      pos_t       tok_index, tok_row, tok_col;
      bit         is_frac;
      int         errors;
      int         records_ok;
      int         bytes_in;
      int         texts_closed;
      int         kind_count[8];

      function new();
         rewind();
      endfunction

      function void rewind();
         mode       = SCAN_IDLE;
         next_index = '0;
         next_row   = pos_t'(1);
         next_col   = pos_t'(1);
         tok_index  = '0;
         tok_row    = '0;
         tok_col    = '0;
         is_frac    = 1'b0;
      endfunction

      function pos_t bump(pos_t v);
         return (v == POS_TOP) ? v : pos_t'(v + 1'b1);
      endfunction

      function bit blank(logic [7:0] c);
         return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
                c == CH_FORMFEED || c == CH_RETURN;
      endfunction

      function bit numeral(logic [7:0] c);
         return c >= CH_ZERO && c <= CH_NINE;
      endfunction

      function bit punct(logic [7:0] c);
         case (c)
            CH_PLUS, CH_MINUS, CH_EQUAL, CH_LESS, CH_GREATER, CH_LBRACE, CH_RBRACE,
            CH_LBRACKET, CH_RBRACKET, CH_LPAREN, CH_RPAREN, CH_DOT, CH_COLON,
            CH_APOS, CH_COMMA: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function void post(logic [KIND_W-1:0] k, pos_t s, pos_t e, pos_t r, pos_t c);
         token_rec_t t;
         if (byte_tokens.size() < GROUP_MAX) begin
            t.kind      = k;
            t.start_pos = s;
            t.end_pos   = e;
            t.line_no   = r;
            t.col_no    = c;
            t.run_end   = 1'b0;
            byte_tokens.push_back(t);
         end
      endfunction

      function void mark();
         tok_index = next_index;
         tok_row   = next_row;
         tok_col   = next_col;
      endfunction

      // A byte with nothing pending: open whatever token it starts.
      function void open_token(logic [7:0] c);
         mode = SCAN_IDLE;
         if (blank(c))
            return;
         if (c == CH_SLASH) begin
            mark();
            mode = SCAN_SLASH;
         end else if (c == CH_QUOTE) begin
            // string body starts past the opening quote
            tok_index = bump(next_index);
            tok_row   = next_row;
            tok_col   = bump(next_col);
            mode      = SCAN_STRING;
         end else if (numeral(c)) begin
            mark();
            is_frac = 1'b0;
            mode    = SCAN_NUMBER;
         end else if (punct(c)) begin
            post(KIND_SYMBOL, next_index, bump(next_index), next_row, next_col);
         end else begin
            mark();
            mode = SCAN_WORD;
         end
      endfunction

      function void in_word(logic [7:0] c);
         if (blank(c) || punct(c) || c == CH_QUOTE) begin
            post(KIND_KEYWORD, tok_index, next_index, tok_row, tok_col);
            open_token(c);
         end else begin
            mode = SCAN_WORD;
         end
      endfunction

      function void in_number(logic [7:0] c);
         if (numeral(c))
            return;
         if (c == CH_DOT || c == CH_LOWER_E || c == CH_UPPER_E) begin
            // second dot or exponent: close as undefined and rescan the byte
            if (is_frac) begin
               post(KIND_UNDEF, tok_index, next_index, tok_row, tok_col);
               open_token(c);
            end else begin
               is_frac = 1'b1;
            end
            return;
         end
         post(is_frac ? KIND_FRAC : KIND_INT, tok_index, next_index, tok_row, tok_col);
         open_token(c);
      endfunction

      // Accepted req transfer: advance the scanner and queue what it yields.
      function void note_byte(logic [7:0] c, logic fin);
         byte_tokens.delete();
         bytes_in++;
         if (c != CH_NUL) begin
            case (mode)
               SCAN_SLASH: begin
                  if (c == CH_SLASH)
                     mode = SCAN_LINE;
                  else if (c == CH_STAR)
                     mode = SCAN_BLOCK;
                  else
                     in_word(c);
               end
               SCAN_LINE: begin
                  if (c == CH_NEWLINE)
                     mode = SCAN_IDLE;
               end
               SCAN_BLOCK: begin
                  if (c == CH_STAR)
                     mode = SCAN_BLOCK_STAR;
               end
               SCAN_BLOCK_STAR: begin
                  if (c == CH_SLASH)
                     mode = SCAN_IDLE;
                  else if (c != CH_STAR)
                     mode = SCAN_BLOCK;
               end
               SCAN_STRING: begin
                  if (c == CH_BACKSLASH) begin
                     mode = SCAN_ESCAPE;
                  end else if (c == CH_QUOTE) begin
                     post(KIND_STRING, tok_index, next_index, tok_row, tok_col);
                     mode = SCAN_IDLE;
                  end
               end
               SCAN_ESCAPE: mode = SCAN_STRING;
               SCAN_NUMBER: in_number(c);
               SCAN_WORD:   in_word(c);
               default:     open_token(c);
            endcase
            if (c == CH_NEWLINE) begin
               next_row = bump(next_row);
               next_col = pos_t'(1);
            end else begin
               next_col = bump(next_col);
            end
            next_index = bump(next_index);
         end
         if (c == CH_NUL || fin) begin
            // flush the pending token, then EOF at the current position
            case (mode)
               SCAN_SLASH, SCAN_WORD:
                  post(KIND_KEYWORD, tok_index, next_index, tok_row, tok_col);
               SCAN_NUMBER:
                  post(is_frac ? KIND_FRAC : KIND_INT, tok_index, next_index, tok_row, tok_col);
               SCAN_STRING, SCAN_ESCAPE:
                  post(KIND_STRING, tok_index, next_index, tok_row, tok_col);
               default: ;
            endcase
            post(KIND_EOF, next_index, next_index, next_row, next_col);
            texts_closed++;
            rewind();
         end
         foreach (byte_tokens[i]) begin
            byte_tokens[i].run_end = (i == byte_tokens.size() - 1);
            expected_tokens.push_back(byte_tokens[i]);
         end
      endfunction

      function int field_diff(string name, longint unsigned want, longint unsigned got);
         if (want == got)
            return 0;
         $display("t=%0d ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1;
      endfunction

      // Accepted rsp transfer: unpack and compare with the oldest expectation.
      function void check_record(logic [KIND_W-1:0] k, logic [DATA_W-1:0] d, logic last);
         token_rec_t want;
         token_rec_t got;
         int         bad;
         got.kind      = k;
         got.start_pos = d[0 +: POS_W];
         got.end_pos   = d[POS_W +: POS_W];
         got.line_no   = d[2 * POS_W +: POS_W];
         got.col_no    = d[3 * POS_W +: POS_W];
         got.run_end   = last;
         if (expected_tokens.size() == 0) begin
            $display("t=%0d ns: record with none expected, expected nothing, actual kind %0d start %0d",
                     $time, got.kind, got.start_pos);
            errors++;
            return;
         end
         want = expected_tokens.pop_front();
         bad  = 0;
         bad += field_diff("token_kind", 64'(want.kind), 64'(got.kind));
         bad += field_diff("start_pos", 64'(want.start_pos), 64'(got.start_pos));
         bad += field_diff("end_pos", 64'(want.end_pos), 64'(got.end_pos));
         bad += field_diff("line_number", 64'(want.line_no), 64'(got.line_no));
         bad += field_diff("column_number", 64'(want.col_no), 64'(got.col_no));
         bad += field_diff("run_end", 64'(want.run_end), 64'(got.run_end));
         if (bad == 0) begin
            records_ok++;
            kind_count[got.kind]++;
         end else begin
            errors++;
         end
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata  = '0;   // [7:0] text_byte
   logic              req_tlast  = 1'b0; // final_byte
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // start, end, line, column
   logic [KIND_W-1:0] rsp_tuser;         // token_kind
   logic              rsp_tlast;         // run_end

   token_ledger ledger = new();
   int          rsp_count = 0;
   int          burst_left = 0;
   logic [7:0]  text_q[$];

   source_text_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Sample the rsp side on the rising edge; inputs only ever move on the falling one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_record(rsp_tuser, rsp_tdata, rsp_tlast);
         rsp_count++;
      end
   end

   // Receiver: alternate ready and stall stretches of random length. Once, hold off
   // for a long stretch so the result queue fills and req_tready drops.
   initial begin : rsp_side
      int phase_left;
      int hold_left;
      bit ready_phase;
      bit held;
      phase_left  = 0;
      hold_left   = 0;
      ready_phase = 1'b0;
      held        = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && rsp_count >= HOLD_AFTER) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
            ready_phase = 1'b0;
            phase_left  = 0;
         end else if (phase_left > 0) begin
            phase_left--;
         end else begin
            ready_phase = !ready_phase;
            phase_left  = ready_phase ? $urandom_range(0, 40) : $urandom_range(0, 5);
            rsp_tready <= ready_phase;
         end
      end
   end

   // Offer one byte and hold it until the transfer; gaps come between bursts.
   task automatic push_byte(input logic [7:0] c, input logic fin);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      ledger.note_byte(c, fin);
      burst_left--;
   endtask

   task automatic send_string(input string s, input logic fin);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i], fin && i == s.len() - 1);
   endtask

   task automatic send_queue(input logic fin);
      foreach (text_q[i])
         push_byte(text_q[i], fin && i == text_q.size() - 1);
   endtask

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0: return 8'($urandom_range(8'h41, 8'h5A));
         1: return 8'h5F;
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return CH_TAB;
         1: return CH_NEWLINE;
         2: return CH_VTAB;
         3: return CH_FORMFEED;
         4: return CH_RETURN;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] exp_char();
      case ($urandom_range(0, 2))
         0: return CH_DOT;
         1: return CH_LOWER_E;
         default: return CH_UPPER_E;
      endcase
   endfunction

   function automatic logic [7:0] digit_char();
      return 8'($urandom_range(CH_ZERO, CH_NINE));
   endfunction

   // Append one well-formed token (or a little noise) to the text under construction.
   task automatic add_token();
      int         pick;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         repeat ($urandom_range(1, 6))
            text_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                                         : word_char());
      end else if (pick < 35) begin
         repeat ($urandom_range(1, 4)) text_q.push_back(digit_char());
         if ($urandom_range(0, 1)) begin
            text_q.push_back(exp_char());
            repeat ($urandom_range(0, 3)) text_q.push_back(digit_char());
            if ($urandom_range(0, 3) == 0) begin
               text_q.push_back(exp_char());
               repeat ($urandom_range(0, 2)) text_q.push_back(digit_char());
            end
         end
      end else if (pick < 48) begin
         text_q.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 6) == 0) begin
               // escape: any byte but NUL rides along
               text_q.push_back(CH_BACKSLASH);
               text_q.push_back(8'($urandom_range(1, 255)));
            end else begin
               c = ($urandom_range(0, 9) == 0) ? CH_NEWLINE : 8'($urandom_range(32, 126));
               text_q.push_back((c == CH_QUOTE || c == CH_BACKSLASH) ? word_char() : c);
            end
         end
         if ($urandom_range(0, 9) != 0)
            text_q.push_back(CH_QUOTE);
      end else if (pick < 63) begin
         text_q.push_back(SYMBOL_CHARS[$urandom_range(0, SYMBOL_CHARS.len() - 1)]);
      end else if (pick < 73) begin
         text_q.push_back(blank_char());
      end else if (pick < 80) begin
         text_q.push_back(CH_SLASH);
         text_q.push_back(CH_SLASH);
         repeat ($urandom_range(0, 8)) begin
            c = 8'($urandom_range(1, 255));
            text_q.push_back((c == CH_NEWLINE) ? CH_SPACE : c);
         end
         text_q.push_back(CH_NEWLINE);
      end else if (pick < 87) begin
         text_q.push_back(CH_SLASH);
         text_q.push_back(CH_STAR);
         repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 3))
               0: text_q.push_back(CH_STAR);
               1: text_q.push_back(CH_SLASH);
               default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
         end
         text_q.push_back(CH_STAR);
         text_q.push_back(CH_SLASH);
      end else begin
         repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 1))
         text_q.push_back(blank_char());
   endtask

   // Build one random text, sometimes cut off inside an opener, and send it.
   task automatic send_random_text(output int sent);
      logic fin;
      text_q.delete();
      repeat ($urandom_range(3, 30)) add_token();
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 4))
            0: begin text_q.push_back(CH_SLASH); text_q.push_back(CH_STAR);
                     text_q.push_back(word_char()); end
            1: begin text_q.push_back(CH_QUOTE); text_q.push_back(word_char()); end
            2: begin text_q.push_back(digit_char()); text_q.push_back(CH_DOT); end
            3: begin text_q.push_back(CH_SLASH); text_q.push_back(CH_SLASH); end
            default: text_q.push_back(CH_SLASH);
         endcase
      end
      // end of text: either a NUL (tlast random) or tlast on the last real byte
      if ($urandom_range(0, 1)) begin
         text_q.push_back(CH_NUL);
         fin = 1'($urandom_range(0, 1));
      end else begin
         fin = 1'b1;
      end
      send_queue(fin);
      sent = text_q.size();
   endtask

   initial begin : stimulus
      int random_sent;
      int sent;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: frac then undefined, exponent restarting as a keyword, symbol, string
      // with an escaped quote, a block comment that slash-star-slash does not close, a
      // line comment, a high byte as a keyword, a number closed by a symbol on the
      // last byte (three records at once), an unterminated string cut by NUL, and a
      // lone slash at the end.
      send_string("1.2e+\"\\\"\"/*/*///\n", 1'b0);
      push_byte(8'hFF, 1'b0);
      send_string("\t9(", 1'b1);
      send_string("\"a", 1'b0);
      push_byte(CH_NUL, 1'b0);
      send_string("/", 1'b1);

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         send_random_text(sent);
         random_sent += sent;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (ledger.expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Lexed %0d bytes in %0d texts: directed corner cases, then random texts under sender gaps and receiver stalls.",
               ledger.bytes_in, ledger.texts_closed);
      $display("Matched %0d records: eof %0d keyword %0d int %0d frac %0d string %0d symbol %0d undefined %0d",
               ledger.records_ok, ledger.kind_count[KIND_EOF], ledger.kind_count[KIND_KEYWORD],
               ledger.kind_count[KIND_INT], ledger.kind_count[KIND_FRAC],
               ledger.kind_count[KIND_STRING], ledger.kind_count[KIND_SYMBOL],
               ledger.kind_count[KIND_UNDEF]);
      if (ledger.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: a correct run needs well under half a millisecond.
   initial begin : watchdog
      #4_000_000;
      $display("Timed out with %0d records still expected.", ledger.expected_tokens.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
